>>> src/hcfd_pkg.sv
// Shared constants and types for the Hermite curve forward-difference block.
// No dependencies; every other file imports this package.
package hcfd_pkg;

  // Fixed widths of the input and output words
  localparam int IN_W      = 10;
  localparam int OUT_W     = 21;
  localparam int FRAC_BITS = 8;

  // Saturation limits of a curve point
  localparam int OUT_MAX = 1048575;
  localparam int OUT_MIN = -1048576;

  typedef logic signed [OUT_W-1:0] point_t;
  typedef logic        [IN_W-1:0]  coord_in_t;

endpackage

>>> src/hcfd_front.sv
// Front end: accepts input words, keeps the stored anchor/tangent pair and
// forms the cubic coefficients of each segment. Depends on hcfd_pkg.
module hcfd_front
  import hcfd_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int CW         = COORD_BITS + 4,
  parameter int AXW        = 3 * CW + COORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  coord_in_t          in_anchor_x,
  input  coord_in_t          in_anchor_y,
  input  coord_in_t          in_handle_x,
  input  coord_in_t          in_handle_y,
  input  logic               in_start_req,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [2*AXW-1:0]   push_data
);

  logic                         accept;
  logic        [COORD_BITS-1:0] anchor   [2];
  logic        [COORD_BITS-1:0] handle   [2];
  logic signed [COORD_BITS:0]   tangent  [2];
  logic        [COORD_BITS-1:0] prev_anchor_r  [2];
  logic signed [COORD_BITS:0]   prev_tangent_r [2];
  logic                         primed_r;

  // Keep only the low coordinate bits of each input
  assign anchor[0] = COORD_BITS'(in_anchor_x);
  assign anchor[1] = COORD_BITS'(in_anchor_y);
  assign handle[0] = COORD_BITS'(in_handle_x);
  assign handle[1] = COORD_BITS'(in_handle_y);

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && !in_start_req && primed_r;

  // Tangent and Hermite coefficients per axis
  always_comb begin
    logic signed [CW-1:0] p1, p4, r1, r4, a, b, c;
    for (int k = 0; k < 2; k++) begin
      tangent[k] = $signed({1'b0, handle[k]}) - $signed({1'b0, anchor[k]});
      p1 = $signed({4'b0000, prev_anchor_r[k]});
      p4 = $signed({4'b0000, anchor[k]});
      r1 = CW'(prev_tangent_r[k]);
      r4 = CW'(tangent[k]);
      a  = (p1 <<< 1) - (p4 <<< 1) + r1 + r4;
      b  = (p4 + (p4 <<< 1)) - (p1 + (p1 <<< 1)) - (r1 <<< 1) - r4;
      c  = r1;
      push_data[k*AXW +: AXW] = {a, b, c, prev_anchor_r[k]};
    end
  end

  // Hold the new pair as the stored pair on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        prev_anchor_r[k]  <= '0;
        prev_tangent_r[k] <= '0;
      end
    end else if (accept) begin
      primed_r <= 1'b1;
      for (int k = 0; k < 2; k++) begin
        prev_anchor_r[k]  <= anchor[k];
        prev_tangent_r[k] <= tangent[k];
      end
    end
  end

endmodule

>>> src/hcfd_queue.sv
// Two-entry register queue for segment coefficients between front and back.
// Depends on hcfd_pkg.
module hcfd_queue
  import hcfd_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = 2;

  logic [W-1:0] mem [DEPTH];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/hcfd_back.sv
// Back end: loads one segment's coefficients and steps the forward
// differences, one rounded point per cycle unless out_ready stalls it. Depends on hcfd_pkg.
module hcfd_back
  import hcfd_pkg::*;
#(
  parameter int LOG2_STEPS = 5,
  parameter int COORD_BITS = 10,
  parameter int CW         = COORD_BITS + 4,
  parameter int AXW        = 3 * CW + COORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [2*AXW-1:0] pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output point_t           out_point_x,
  output point_t           out_point_y,
  output logic             out_last
);

  localparam int S  = 3 * LOG2_STEPS;
  localparam int FW = COORD_BITS + S + 6;
  localparam int PW = FW + FRAC_BITS;
  localparam int JW = LOG2_STEPS + 1;
  localparam logic [JW-1:0]        LAST_J = JW'(1 << LOG2_STEPS);
  localparam logic signed [PW-1:0] HALF   = PW'(1 << (S - 1));
  localparam logic signed [PW-1:0] SAT_HI = PW'(OUT_MAX);
  localparam logic signed [PW-1:0] SAT_LO = PW'(OUT_MIN);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state_r, state_nxt;
  logic [JW-1:0]        j_r;
  logic signed [FW-1:0] f_r  [2];
  logic signed [FW-1:0] d1_r [2];
  logic signed [FW-1:0] d2_r [2];
  logic signed [FW-1:0] d3_r [2];
  logic signed [FW-1:0] f0   [2];
  logic signed [FW-1:0] d10  [2];
  logic signed [FW-1:0] d20  [2];
  logic signed [FW-1:0] d30  [2];
  logic                 out_valid_r;
  point_t               out_x_r;
  point_t               out_y_r;
  logic                 out_last_r;
  logic                 load;
  logic                 emit;

  // Round to nearest (ties up) at 8 fraction bits, then saturate
  function automatic point_t to_point(input logic signed [FW-1:0] f);
    logic signed [PW-1:0] v;
    logic signed [PW-1:0] q;
    v = (PW'(f) <<< FRAC_BITS) + HALF;
    q = v >>> S;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[OUT_W-1:0];
  endfunction

  assign pop_ready = (state_r == ST_IDLE);
  assign load      = pop_valid && pop_ready;
  assign emit      = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  // Initial value and differences from a, b, c, d per axis
  always_comb begin
    logic [AXW-1:0]         slice;
    logic signed [FW-1:0]   aw, bw, cw, dw, a6;
    for (int k = 0; k < 2; k++) begin
      slice  = pop_data[k*AXW +: AXW];
      aw     = FW'($signed(slice[AXW-1 -: CW]));
      bw     = FW'($signed(slice[AXW-CW-1 -: CW]));
      cw     = FW'($signed(slice[AXW-2*CW-1 -: CW]));
      dw     = $signed(FW'(slice[COORD_BITS-1:0]));
      a6     = (aw <<< 2) + (aw <<< 1);
      f0[k]  = dw <<< S;
      d10[k] = aw + (bw <<< LOG2_STEPS) + (cw <<< (2 * LOG2_STEPS));
      d20[k] = a6 + (bw <<< (LOG2_STEPS + 1));
      d30[k] = a6;
    end
  end

  // Sequencer: idle until a segment is loaded, run for N+1 points
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (load) state_nxt = ST_RUN;
      ST_RUN:  if (emit && (j_r == LAST_J)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        j_r <= '0;
      end else if (emit) begin
        j_r <= j_r + JW'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load or advance the difference registers, register the point
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 2; k++) begin
        f_r[k]  <= f0[k];
        d1_r[k] <= d10[k];
        d2_r[k] <= d20[k];
        d3_r[k] <= d30[k];
      end
    end else if (emit) begin
      for (int k = 0; k < 2; k++) begin
        f_r[k]  <= f_r[k] + d1_r[k];
        d1_r[k] <= d1_r[k] + d2_r[k];
        d2_r[k] <= d2_r[k] + d3_r[k];
      end
    end
    if (emit) begin
      out_x_r    <= to_point(f_r[0]);
      out_y_r    <= to_point(f_r[1]);
      out_last_r <= (j_r == LAST_J);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_last    = out_last_r;

endmodule

>>> src/hermite_curve_forward_diff_top.sv
// Top level of the cubic Hermite curve generator: front, queue and back.
// Depends on hcfd_pkg, hcfd_front, hcfd_queue and hcfd_back.
//
//  channel | ports                                    | moves
//  --------+------------------------------------------+-------------------------
//  input   | in_valid/in_ready, in_anchor_*, in_handle_*, in_start_req | one pair
//  output  | out_valid/out_ready, out_point_*, out_last | one curve point
//
// A start word yields no point. A segment word is pushed into the queue when
// the front accepts it, then the back loads it and steps the difference
// registers for 2^LOG2_STEPS+1 points, one point per cycle unless stalled.
// A two-entry coefficient queue lets the front keep accepting words while it has room.
// Reset (synchronous) empties the queue and clears the stored pair.
// Low out_ready holds the current point and stalls the back.
module hermite_curve_forward_diff_top
  import hcfd_pkg::*;
#(
  parameter int LOG2_STEPS = 5,
  parameter int COORD_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  coord_in_t in_anchor_x,
  input  coord_in_t in_anchor_y,
  input  coord_in_t in_handle_x,
  input  coord_in_t in_handle_y,
  input  logic      in_start_req,
  output logic      out_valid,
  input  logic      out_ready,
  output point_t    out_point_x,
  output point_t    out_point_y,
  output logic      out_last
);

  localparam int CW  = COORD_BITS + 4;
  localparam int AXW = 3 * CW + COORD_BITS;

  logic             push_valid;
  logic             push_ready;
  logic [2*AXW-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [2*AXW-1:0] pop_data;

  // Accept words and form coefficients
  hcfd_front #(
    .COORD_BITS (COORD_BITS),
    .CW         (CW),
    .AXW        (AXW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_anchor_x  (in_anchor_x),
    .in_anchor_y  (in_anchor_y),
    .in_handle_x  (in_handle_x),
    .in_handle_y  (in_handle_y),
    .in_start_req (in_start_req),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  // Buffer segments between front and back
  hcfd_queue #(
    .W (2 * AXW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Step the curve and drive points
  hcfd_back #(
    .LOG2_STEPS (LOG2_STEPS),
    .COORD_BITS (COORD_BITS),
    .CW         (CW),
    .AXW        (AXW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_last    (out_last)
  );

endmodule
